// File: src/graphlet_class_from_edges_defines.svh
// Assertion macros used by the RTL.
// Both sample on clk and are disabled while rst_n is low.
`ifndef GRAPHLET_CLASS_FROM_EDGES_DEFINES_SVH
`define GRAPHLET_CLASS_FROM_EDGES_DEFINES_SVH

// Same-cycle implication.
`define GCFE_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gcfe: implication check failed");

// Next-cycle implication.
`define GCFE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gcfe: next-cycle check failed");

`endif

// File: src/gcfe_pkg.sv
`timescale 1ns / 1ps

package gcfe_pkg;

  localparam int NV = 5;  // max vertices

  typedef logic [2:0] n_t;
  typedef logic [9:0] edges_t;
  typedef logic [4:0] id_t;
  typedef logic [NV-1:0] row_t;
  typedef row_t [NV-1:0] adj_t;
  typedef logic [2:0] deg_t;
  typedef deg_t [NV-1:0] deg_vec_t;
  typedef logic [2:0] vidx_t;
  typedef logic [2:0] cnt_t;
  typedef cnt_t [NV-1:0] hist_t;  // hist[d] = number of live vertices of degree d

  // Internal class codes beyond the visible range mark the two split cases.
  localparam id_t ID_NONE        = 5'd0;
  localparam id_t ID_MAX         = 5'd29;
  localparam id_t ID_LEAF_NB2    = 5'd13;
  localparam id_t ID_LEAF_OTHER  = 5'd16;
  localparam id_t ID_HOUSE_ALL2  = 5'd20;
  localparam id_t ID_HOUSE_OTHER = 5'd21;
  localparam id_t CODE_LEAF      = 5'd30;
  localparam id_t CODE_HOUSE     = 5'd31;

  typedef struct packed {
    id_t  code;
    logic leaf_nb2;
    logic hub_all2;
  } match_t;

  // Degree histogram -> class code. Counts sum to the vertex count, so the
  // histogram alone identifies the sorted degree sequence.
  function automatic id_t class_of(hist_t h);
    id_t c;
    case ({h[0], h[1], h[2], h[3], h[4]})
      {3'd0, 3'd2, 3'd1, 3'd0, 3'd0}: c = 5'd1;
      {3'd0, 3'd0, 3'd3, 3'd0, 3'd0}: c = 5'd2;
      {3'd0, 3'd2, 3'd2, 3'd0, 3'd0}: c = 5'd3;
      {3'd0, 3'd3, 3'd0, 3'd1, 3'd0}: c = 5'd4;
      {3'd0, 3'd0, 3'd4, 3'd0, 3'd0}: c = 5'd5;
      {3'd0, 3'd1, 3'd2, 3'd1, 3'd0}: c = 5'd6;
      {3'd0, 3'd0, 3'd2, 3'd2, 3'd0}: c = 5'd7;
      {3'd0, 3'd0, 3'd0, 3'd4, 3'd0}: c = 5'd8;
      {3'd0, 3'd2, 3'd3, 3'd0, 3'd0}: c = 5'd9;
      {3'd0, 3'd3, 3'd1, 3'd1, 3'd0}: c = 5'd10;
      {3'd0, 3'd4, 3'd0, 3'd0, 3'd1}: c = 5'd11;
      {3'd0, 3'd2, 3'd1, 3'd2, 3'd0}: c = 5'd12;
      {3'd0, 3'd1, 3'd3, 3'd1, 3'd0}: c = CODE_LEAF;
      {3'd0, 3'd2, 3'd2, 3'd0, 3'd1}: c = 5'd14;
      {3'd0, 3'd0, 3'd5, 3'd0, 3'd0}: c = 5'd15;
      {3'd0, 3'd1, 3'd2, 3'd1, 3'd1}: c = 5'd17;
      {3'd0, 3'd0, 3'd4, 3'd0, 3'd1}: c = 5'd18;
      {3'd0, 3'd1, 3'd1, 3'd3, 3'd0}: c = 5'd19;
      {3'd0, 3'd0, 3'd3, 3'd2, 3'd0}: c = CODE_HOUSE;
      {3'd0, 3'd0, 3'd3, 3'd0, 3'd2}: c = 5'd22;
      {3'd0, 3'd1, 3'd0, 3'd3, 3'd1}: c = 5'd23;
      {3'd0, 3'd0, 3'd2, 3'd2, 3'd1}: c = 5'd24;
      {3'd0, 3'd0, 3'd1, 3'd4, 3'd0}: c = 5'd25;
      {3'd0, 3'd0, 3'd1, 3'd2, 3'd2}: c = 5'd26;
      {3'd0, 3'd0, 3'd0, 3'd4, 3'd1}: c = 5'd27;
      {3'd0, 3'd0, 3'd0, 3'd2, 3'd3}: c = 5'd28;
      {3'd0, 3'd0, 3'd0, 3'd0, 3'd5}: c = 5'd29;
      default:                        c = ID_NONE;
    endcase
    return c;
  endfunction

endpackage

// File: src/graphlet_class_from_edges.sv
`timescale 1ns / 1ps

// Graphlet classifier for induced subgraphs of 3, 4 or 5 vertices.
// Input channel (in_valid/in_ready): one word carries in_node_count and
// in_edge_bits, bit k set when pair k of the ordered upper triangle
// (0,1),(0,2),... of an in_node_count-vertex graph is an edge. Higher bits
// are ignored. A node count other than 3..5 yields class 0.
// Output channel (out_valid/out_ready): one word per input word, in order,
// carrying out_graphlet_id (1..29, 0 when no degree pattern matches).
// Pipeline stages, each with its own register: adjacency/degree,
// histogram/vertex pick, class lookup/neighbor check, output register.
// Throughput: one word per cycle; each stage hands over independently, so
// the pipe keeps accepting while bubbles remain ahead of a stalled output.
// A stalled receiver holds out_valid and the word; back-pressure ripples
// up stage by stage and in_ready drops only once every stage is full.
// Reset (rst_n low, synchronous): all stages drain to empty, out_valid low.
// No configuration and no stored state beyond the pipeline.
module graphlet_class_from_edges (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  gcfe_pkg::n_t     in_node_count,
  input  gcfe_pkg::edges_t in_edge_bits,
  output logic            out_valid,
  input  logic            out_ready,
  output gcfe_pkg::id_t    out_graphlet_id
);
  import gcfe_pkg::*;
  `include "graphlet_class_from_edges_defines.svh"

  // Adjacency from the packed pair list; pair numbering depends on n.
  function automatic adj_t build_adj(n_t n, edges_t e);
    adj_t  a;
    logic [3:0] k;
    a = '0;
    k = '0;
    for (int i = 0; i < NV; i++) begin
      for (int j = 0; j < NV; j++) begin
        if (j > i && n_t'(j) < n) begin
          if (e[k]) begin
            a[i][j] = 1'b1;
            a[j][i] = 1'b1;
          end
          k = k + 4'd1;
        end
      end
    end
    return a;
  endfunction

  function automatic logic adj_sym(adj_t a);
    logic s;
    s = 1'b1;
    for (int i = 0; i < NV; i++) begin
      for (int j = 0; j < NV; j++) begin
        if (a[i][j] != a[j][i]) s = 1'b0;
      end
      if (a[i][i]) s = 1'b0;
    end
    return s;
  endfunction

  // Per-stage handshake: a stage loads when it is empty or its word moves on.
  logic rdy1, rdy2, rdy3, rdy4;

  // Stage 1: adjacency, degrees, live-vertex mask
  logic     s1_valid_r;
  logic     s1_ok_r, s1_ok_nxt;
  row_t     s1_live_r, s1_live_nxt;
  adj_t     s1_adj_r, s1_adj_nxt;
  deg_vec_t s1_deg_r, s1_deg_nxt;

  // Stage 2: degree histogram, first leaf and first degree-3 vertex
  logic     s2_valid_r;
  logic     s2_ok_r;
  adj_t     s2_adj_r;
  deg_vec_t s2_deg_r;
  hist_t    s2_hist_r, s2_hist_nxt;
  vidx_t    s2_leaf_r, s2_leaf_nxt;
  vidx_t    s2_hub_r, s2_hub_nxt;

  // Stage 3: class code and split-case flags
  logic   s3_valid_r;
  match_t s3_m_r, s3_m_nxt;

  // Stage 4: output register
  logic out_valid_r;
  id_t  out_id_r, out_id_nxt;

  assign rdy4     = !out_valid_r || out_ready;
  assign rdy3     = !s3_valid_r || rdy4;
  assign rdy2     = !s2_valid_r || rdy3;
  assign rdy1     = !s1_valid_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    s1_ok_nxt  = in_node_count inside {[3'd3:3'd5]};
    s1_adj_nxt = build_adj(in_node_count, in_edge_bits);
    case (in_node_count)
      3'd3:    s1_live_nxt = 5'b00111;
      3'd4:    s1_live_nxt = 5'b01111;
      3'd5:    s1_live_nxt = 5'b11111;
      default: s1_live_nxt = 5'b00000;
    endcase
    for (int i = 0; i < NV; i++) begin
      s1_deg_nxt[i] = deg_t'($countones(s1_adj_nxt[i]));
    end
  end

  always_comb begin
    s2_hist_nxt = '0;
    s2_leaf_nxt = '0;
    s2_hub_nxt  = '0;
    for (int d = 0; d < NV; d++) begin
      for (int i = 0; i < NV; i++) begin
        if (s1_live_r[i] && s1_deg_r[i] == deg_t'(d)) begin
          s2_hist_nxt[d] = s2_hist_nxt[d] + cnt_t'(1);
        end
      end
    end
    // lowest-numbered vertex wins: scan downward, last hit sticks
    for (int i = NV - 1; i >= 0; i--) begin
      if (s1_deg_r[i] == deg_t'(1)) s2_leaf_nxt = vidx_t'(i);
      if (s1_deg_r[i] == deg_t'(3)) s2_hub_nxt  = vidx_t'(i);
    end
  end

  gcfe_match u_match (
    .ok   (s2_ok_r),
    .hist (s2_hist_r),
    .adj  (s2_adj_r),
    .deg  (s2_deg_r),
    .leaf (s2_leaf_r),
    .hub  (s2_hub_r),
    .m    (s3_m_nxt)
  );

  always_comb begin
    case (s3_m_r.code)
      CODE_LEAF:  out_id_nxt = s3_m_r.leaf_nb2 ? ID_LEAF_NB2 : ID_LEAF_OTHER;
      CODE_HOUSE: out_id_nxt = s3_m_r.hub_all2 ? ID_HOUSE_ALL2 : ID_HOUSE_OTHER;
      default:    out_id_nxt = s3_m_r.code;
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) s1_valid_r  <= in_valid;
      if (rdy2) s2_valid_r  <= s1_valid_r;
      if (rdy3) s3_valid_r  <= s2_valid_r;
      if (rdy4) out_valid_r <= s3_valid_r;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_ok_r   <= s1_ok_nxt;
      s1_live_r <= s1_live_nxt;
      s1_adj_r  <= s1_adj_nxt;
      s1_deg_r  <= s1_deg_nxt;
    end
    if (rdy2 && s1_valid_r) begin
      s2_ok_r   <= s1_ok_r;
      s2_adj_r  <= s1_adj_r;
      s2_deg_r  <= s1_deg_r;
      s2_hist_r <= s2_hist_nxt;
      s2_leaf_r <= s2_leaf_nxt;
      s2_hub_r  <= s2_hub_nxt;
    end
    if (rdy3 && s2_valid_r) begin
      s3_m_r <= s3_m_nxt;
    end
    if (rdy4 && s3_valid_r) begin
      out_id_r <= out_id_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_graphlet_id = out_id_r;

  `GCFE_ASSERT_IMPLY(a_adj_sym, s1_valid_r, adj_sym(s1_adj_r))
  `GCFE_ASSERT_IMPLY(a_live_cnt, s1_valid_r && s1_ok_r, $countones(s1_live_r) >= 3)
  `GCFE_ASSERT_IMPLY(a_id_range, out_valid, out_graphlet_id <= ID_MAX)
  `GCFE_ASSERT_IMPLY(a_empty_ready, !s1_valid_r, in_ready)
  `GCFE_ASSERT_NEXT(a_s3_hold, s3_valid_r && !rdy4, s3_valid_r)

endmodule

// File: src/gcfe_match.sv
`timescale 1ns / 1ps

// Class lookup plus the neighbor-degree checks for the two split cases.
module gcfe_match (
  input  logic              ok,
  input  gcfe_pkg::hist_t    hist,
  input  gcfe_pkg::adj_t     adj,
  input  gcfe_pkg::deg_vec_t deg,
  input  gcfe_pkg::vidx_t    leaf,
  input  gcfe_pkg::vidx_t    hub,
  output gcfe_pkg::match_t   m
);
  import gcfe_pkg::*;

  vidx_t nb;
  row_t  leaf_row;
  row_t  hub_row;
  row_t  deg2_mask;

  always_comb begin
    leaf_row = adj[leaf];
    hub_row  = adj[hub];
    nb = '0;
    for (int j = NV - 1; j >= 0; j--) begin
      if (leaf_row[j]) nb = vidx_t'(j);
    end
    for (int j = 0; j < NV; j++) begin
      deg2_mask[j] = (deg[j] == deg_t'(2));
    end
    m.code     = ok ? class_of(hist) : ID_NONE;
    m.leaf_nb2 = (deg[nb] == deg_t'(2));
    m.hub_all2 = &(~hub_row | deg2_mask);
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import gcfe_pkg::*;

  // Cycles without any handshake before the run is declared hung. The slowest
  // correct stretch is the longest sender gap plus a receiver that takes one word
  // in four, so this is far above any legal pause.
  localparam int WATCHDOG_LIMIT = 4000;
  // Three-stage pipe plus output register; the wait after the last word catches strays.
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_WORDS   = 630;

  typedef enum int {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_SELDOM,
    RX_EVERY_FOURTH
  } rx_mode_t;

  // One outstanding classification: the input word and the class it must give.
  typedef struct {
    n_t     n;
    edges_t edges;
    id_t    id;
  } class_exp_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  n_t     in_node_count = '0;
  edges_t in_edge_bits = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  id_t    out_graphlet_id;

  class_exp_t pending_classes[$];
  int         errors = 0;
  int         idle_cycles = 0;
  int         burst_left = 0;
  int         stall_phase = 0;
  rx_mode_t   stall_mode = RX_ALWAYS;

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  graphlet_class_from_edges u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_node_count   (in_node_count),
    .in_edge_bits    (in_edge_bits),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_graphlet_id (out_graphlet_id)
  );

  // ---------------------------------------------------------------------------
  // Class predictor. Builds neighbor masks and degrees from the upper-triangle
  // pair bits, sorts the degrees ascending and looks the sequence up. The key
  // is the node count followed by the sorted degrees, one octal digit each;
  // unused slots for 3 or 4 vertices stay zero.
  // ---------------------------------------------------------------------------
  function automatic id_t predict_graphlet(n_t n, edges_t edges);
    row_t        nbr [NV];
    deg_t        deg [NV];
    deg_t        srt [NV];
    deg_t        swap;
    logic [17:0] seq;
    id_t         id;
    int          pair;
    int          leaf;
    int          nb;
    int          hub;
    logic        all2;
    if (n < 3 || n > 5) return ID_NONE;
    for (int v = 0; v < NV; v++) begin
      nbr[v] = '0;
      deg[v] = '0;
      srt[v] = '0;
    end
    // pair numbering depends on n: (0,1),(0,2),...,(0,n-1),(1,2),...
    pair = 0;
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        if (edges[pair]) begin
          nbr[i][j] = 1'b1;
          nbr[j][i] = 1'b1;
          deg[i]++;
          deg[j]++;
        end
        pair++;
      end
    end
    for (int i = 0; i < n; i++) srt[i] = deg[i];
    for (int i = 0; i < n - 1; i++) begin
      for (int j = 0; j < n - 1 - i; j++) begin
        if (srt[j] > srt[j + 1]) begin
          swap       = srt[j];
          srt[j]     = srt[j + 1];
          srt[j + 1] = swap;
        end
      end
    end
    seq = {n, srt[0], srt[1], srt[2], srt[3], srt[4]};
    case (seq)
      18'o311200: id = 5'd1;
      18'o322200: id = 5'd2;
      18'o411220: id = 5'd3;
      18'o411130: id = 5'd4;
      18'o422220: id = 5'd5;
      18'o412230: id = 5'd6;
      18'o422330: id = 5'd7;
      18'o433330: id = 5'd8;
      18'o511222: id = 5'd9;
      18'o511123: id = 5'd10;
      18'o511114: id = 5'd11;
      18'o511233: id = 5'd12;
      18'o512223: id = CODE_LEAF;   // split on the leaf's neighbor
      18'o511224: id = 5'd14;
      18'o522222: id = 5'd15;
      18'o512234: id = 5'd17;
      18'o522224: id = 5'd18;
      18'o512333: id = 5'd19;
      18'o522233: id = CODE_HOUSE;  // split on the first hub's neighbors
      18'o522244: id = 5'd22;
      18'o513334: id = 5'd23;
      18'o522334: id = 5'd24;
      18'o523333: id = 5'd25;
      18'o523344: id = 5'd26;
      18'o533334: id = 5'd27;
      18'o533444: id = 5'd28;
      18'o544444: id = ID_MAX;
      default:    id = ID_NONE;
    endcase
    if (id == CODE_LEAF) begin
      // lowest numbered degree-1 vertex, then its lowest numbered neighbor
      leaf = 0;
      for (int v = NV - 1; v >= 0; v--) if (v < n && deg[v] == 3'd1) leaf = v;
      nb = 0;
      for (int v = NV - 1; v >= 0; v--) if (nbr[leaf][v]) nb = v;
      id = (deg[nb] == 3'd2) ? ID_LEAF_NB2 : ID_LEAF_OTHER;
    end else if (id == CODE_HOUSE) begin
      hub = 0;
      for (int v = NV - 1; v >= 0; v--) if (v < n && deg[v] == 3'd3) hub = v;
      all2 = 1'b1;
      for (int v = 0; v < NV; v++) if (nbr[hub][v] && deg[v] != 3'd2) all2 = 1'b0;
      id = all2 ? ID_HOUSE_ALL2 : ID_HOUSE_OTHER;
    end
    return id;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Sender. Entered and left at a falling edge. Words go out in bursts of
  // random length; before a new burst valid may drop for a random gap. Long
  // bursts give stretches with no idling at all. The expected class is
  // queued at the edge where the word is taken.
  // ---------------------------------------------------------------------------
  task automatic send_word(input n_t n, input edges_t edges);
    class_exp_t item;
    int         gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 3);
      burst_left = ($urandom_range(0, 5) == 0) ? 48 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_node_count <= n;
    in_edge_bits  <= edges;
    do @(posedge clk); while (!in_ready);
    item.n     = n;
    item.edges = edges;
    item.id    = predict_graphlet(n, edges);
    pending_classes = {pending_classes, item};
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stall pattern: each stall_phase window picks a mode, from always
  // ready down to one word in four, so stalls land on every pipe stage.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_phase % 64 == 0) stall_mode = rx_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      RX_ALWAYS:       out_ready <= 1'b1;
      RX_MOSTLY:       out_ready <= ($urandom_range(0, 99) < 75);
      RX_SELDOM:       out_ready <= ($urandom_range(0, 99) < 25);
      RX_EVERY_FOURTH: out_ready <= (stall_phase % 4 == 0);
      default:         out_ready <= 1'b1;
    endcase
    stall_phase++;
  end

  // Result checker: each word taken on the output must match the oldest
  // expected class.
  always @(posedge clk) begin : check_words
    class_exp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_classes.size() == 0) begin
        report_mismatch($sformatf("word with id %0d and nothing expected", out_graphlet_id));
      end else begin
        want = pending_classes.pop_front();
        if (out_graphlet_id !== want.id) begin
          report_mismatch($sformatf("n=%0d edges=%03h: id %0d, expected %0d",
                                    want.n, want.edges, out_graphlet_id, want.id));
        end
      end
    end
  end

  // Watchdog: any handshake on either channel counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
               WATCHDOG_LIMIT, pending_classes.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every node count 0..7 on a full edge mask: out-of-range counts give 0,
  // 3..5 give the triangle, K4 and K5. Plus an empty 5-vertex graph.
  task automatic test_node_count_range();
    for (int v = 0; v < 8; v++) send_word(n_t'(v), '1);
    send_word(3'd5, '0);
  endtask

  // Pair bits beyond the last pair for n must be ignored.
  task automatic test_unused_pairs();
    send_word(3'd3, 10'h3F8);  // no live pair set -> unmatched
    send_word(3'd3, 10'h3FB);  // 3-path through vertex 0
    send_word(3'd4, 10'h3C7);  // star on vertex 0
  endtask

  // The two degree sequences that need a neighbor check, in more than one
  // labeling so the lowest-index vertex pick matters.
  task automatic test_split_sequences();
    send_word(3'd5, 10'd913);  // tail off a triangle, leaf at 0: leaf's neighbor has degree 2
    send_word(3'd5, 10'd659);  // same shape, leaf at 4
    send_word(3'd5, 10'd721);  // leaf hung on a vertex of a four-vertex ring
    send_word(3'd5, 10'd126);  // two hubs 0,1 sharing three degree-2 neighbors
    send_word(3'd5, 10'd492);  // same, hubs at 3,4
    send_word(3'd5, 10'd667);  // house: ring of five vertices with one chord
  endtask

  // Connectedness is not checked; isolated vertices make the sequence unmatched.
  task automatic test_disconnected();
    send_word(3'd5, 10'd531);  // triangle plus separate edge, reads as a path class
    send_word(3'd4, 10'd11);   // triangle plus isolated vertex
    send_word(3'd4, 10'd33);   // two disjoint edges
  endtask

  // Random subgraphs, mostly 5 vertices, with sparse, dense and uniform edge
  // masks so all degree shapes turn up; a few words use arbitrary counts.
  task automatic test_random_subgraphs();
    n_t     n;
    edges_t e;
    int     pick;
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) n = n_t'($urandom_range(0, 7));
      else if (pick < 23) n = 3'd3;
      else if (pick < 43) n = 3'd4;
      else n = 3'd5;
      case ($urandom_range(0, 3))
        0:       e = edges_t'($urandom) & edges_t'($urandom);
        1:       e = edges_t'($urandom) | edges_t'($urandom);
        default: e = edges_t'($urandom);
      endcase
      send_word(n, e);
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_node_count_range();
    test_unused_pairs();
    test_split_sequences();
    test_disconnected();
    test_random_subgraphs();
    in_valid <= 1'b0;
    while (pending_classes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
